[rtl/mi3_pkg.sv]
// Shared widths and types for the 3x3 matrix inverse.
`timescale 1ns / 1ps
package mi3_pkg;
  localparam int ElemW  = 32;
  localparam int FracB  = 16;
  localparam int ThrW   = 31;
  localparam int AdjW   = 2 * ElemW + 1;       // cofactor, signed
  localparam int DetW   = 3 * ElemW + 2;       // determinant, signed
  localparam int DenW   = DetW;                // 2*|det|, unsigned
  localparam int QBits  = ElemW + 2;           // quotient bits kept before overflow
  localparam int NumW   = DenW + QBits;        // remainder width in the divider
  localparam int LaneLat  = QBits + 2;
  localparam int FrontLat = 4;
  localparam int PipeLat  = FrontLat + 1 + LaneLat + 1;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef elem_t mat_t [9];
  typedef logic signed [AdjW-1:0] adj_t;
  typedef logic signed [DetW-1:0] det_t;
endpackage

[rtl/mi3_if.sv]
// Valid/ready channels for matrix items and inverse results.
`timescale 1ns / 1ps
interface mi3_in_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t in_r0c0, in_r0c1, in_r0c2;
  elem_t in_r1c0, in_r1c1, in_r1c2;
  elem_t in_r2c0, in_r2c1, in_r2c2;
  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface mi3_out_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t out_r0c0, out_r0c1, out_r0c2;
  elem_t out_r1c0, out_r1c1, out_r1c2;
  elem_t out_r2c0, out_r2c1, out_r2c2;
  logic  singular;
  logic  saturated;
  modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                  out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated,
                  input ready);
  modport sink (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated,
                output ready);
endinterface

[rtl/mi3_front.sv]
// Cofactor and determinant pipeline (four stages).
`timescale 1ns / 1ps
module mi3_front (
  input  logic             clk_i,
  input  logic             en_i,
  input  mi3_pkg::mat_t    elems_i,
  output mi3_pkg::adj_t    adj_o [9],
  output mi3_pkg::det_t    det_o
);
  import mi3_pkg::*;

  localparam int PW = 2 * ElemW;

  // product pairs: adj[k] = e[A]*e[B] - e[C]*e[D]
  localparam int IA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int IB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int IC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int ID [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic signed [PW-1:0]    pa_q [9];
  logic signed [PW-1:0]    pb_q [9];
  elem_t                   ea_q [3];
  adj_t                    adj_b_q [9];
  adj_t                    adj_c_q [9];
  adj_t                    adj_d_q [9];
  elem_t                   eb_q [3];
  logic signed [PW:0]      lo_q [3];
  logic signed [PW:0]      hi_q [3];
  det_t                    det_q;
  det_t                    det_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        pa_q[k]    <= elems_i[IA[k]] * elems_i[IB[k]];
        pb_q[k]    <= elems_i[IC[k]] * elems_i[ID[k]];
        adj_b_q[k] <= AdjW'(pa_q[k]) - AdjW'(pb_q[k]);
        adj_c_q[k] <= adj_b_q[k];
        adj_d_q[k] <= adj_c_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        ea_q[j] <= elems_i[j];
        eb_q[j] <= ea_q[j];
      end
      // row 0 elements times cofactors 0, 3, 6, split into low and high halves
      for (int j = 0; j < 3; j++) begin
        lo_q[j] <= (PW+1)'(eb_q[j]) *
                   (PW+1)'($signed({1'b0, adj_b_q[3*j][ElemW-1:0]}));
        hi_q[j] <= (PW+1)'(eb_q[j]) *
                   (PW+1)'($signed(adj_b_q[3*j][AdjW-1:ElemW]));
      end
      det_q <= det_d;
    end
  end

  // det = sum of lo + (hi << ElemW) over the three row-0 terms
  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + DetW'(lo_q[j]) + (DetW'(hi_q[j]) << ElemW);
    end
  end

  assign adj_o = adj_d_q;
  assign det_o = det_q;
endmodule

[rtl/mi3_lane.sv]
// One divider lane: rounded quotient of cofactor by determinant, with saturation.
`timescale 1ns / 1ps
module mi3_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [mi3_pkg::NumW-1:0]      num_i,
  input  logic [mi3_pkg::DenW-1:0]      den_i,
  input  logic                          neg_i,
  output mi3_pkg::elem_t                res_o,
  output logic                          sat_o
);
  import mi3_pkg::*;

  logic [NumW-1:0]  rem_q [QBits+1];
  logic [DenW-1:0]  den_q [QBits+1];
  logic [QBits-1:0] quo_q [QBits+1];
  logic             big_q [QBits+1];
  logic             neg_q [QBits+1];
  elem_t            res_q;
  logic             sat_q;

  // overflow check first: then the remainder stays below den << QBits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      big_q[0] <= num_i >= {den_i, {QBits{1'b0}}};
      neg_q[0] <= neg_i;
    end
  end

  for (genvar s = 1; s <= QBits; s++) begin : g_stage
    localparam int K = QBits - s;
    logic [NumW-1:0] trial;
    assign trial = NumW'(den_q[s-1]) << K;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den_q[s-1];
        big_q[s] <= big_q[s-1];
        neg_q[s] <= neg_q[s-1];
        if (rem_q[s-1] >= trial) begin
          rem_q[s] <= rem_q[s-1] - trial;
          quo_q[s] <= quo_q[s-1] | (QBits'(1) << K);
        end else begin
          rem_q[s] <= rem_q[s-1];
          quo_q[s] <= quo_q[s-1];
        end
      end
    end
  end

  localparam logic [QBits-1:0] MinMag = QBits'(1) << (ElemW - 1);
  localparam logic [QBits-1:0] MaxPos = MinMag - QBits'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[QBits]) begin
        if (big_q[QBits] || quo_q[QBits] > MinMag) begin
          res_q <= elem_t'(MinMag);
          sat_q <= 1'b1;
        end else begin
          res_q <= elem_t'(-quo_q[QBits]);
          sat_q <= 1'b0;
        end
      end else begin
        if (big_q[QBits] || quo_q[QBits] > MaxPos) begin
          res_q <= elem_t'(MaxPos);
          sat_q <= 1'b1;
        end else begin
          res_q <= elem_t'(quo_q[QBits]);
          sat_q <= 1'b0;
        end
      end
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;
endmodule

[rtl/matrix_inverse_3x3_core.sv]
// Top level: 3x3 fixed-point matrix inverse by adjugate over determinant.
// Usage:
//   in_i carries one matrix (nine signed Q16.16 elements) per transfer;
//   out_o carries the inverse, a singular flag and a saturated flag.
//   cfg_we_i/cfg_wdata_i write the singular threshold (Q15.16 magnitude);
//   write it only while the block is idle.
// Data path: front, numerator register, divider lanes, output register.
// Throughput: one matrix per clock unless stalled; nine divider lanes each
//   retire one quotient bit per stage, 34 stages deep.
// The whole pipeline advances on one enable: it moves whenever the output
//   register is empty or being taken. When the receiver stalls with a result
//   waiting, the pipeline holds and in_i.ready drops.
// Reset clears all valid bits and sets the threshold to one LSB; no item
//   is in flight afterwards.
// A determinant of zero, or one whose truncated magnitude is under the
//   threshold, yields the identity with singular set.
`timescale 1ns / 1ps
module matrix_inverse_3x3_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mi3_pkg::ThrW-1:0]   cfg_wdata_i,
  mi3_in_if.sink                     in_i,
  mi3_out_if.source                  out_o
);
  import mi3_pkg::*;

  logic              en;
  logic [ThrW-1:0]   thr_q;
  logic [PipeLat-1:0] vld_q;
  mat_t              elems;
  adj_t              adj [9];
  det_t              det;

  assign en         = !vld_q[PipeLat-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(1);
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (en) begin
        vld_q <= {vld_q[PipeLat-2:0], in_i.valid};
      end
    end
  end

  assign elems = '{in_i.in_r0c0, in_i.in_r0c1, in_i.in_r0c2,
                   in_i.in_r1c0, in_i.in_r1c1, in_i.in_r1c2,
                   in_i.in_r2c0, in_i.in_r2c1, in_i.in_r2c2};

  // cofactors and determinant
  mi3_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .elems_i (elems),
    .adj_o   (adj),
    .det_o   (det)
  );

  // prepare numerators and denominator for the lanes
  logic [DetW-2:0]  adet;
  logic             det_neg;
  logic [NumW-1:0]  num_q [9];
  logic [DenW-1:0]  den_q;
  logic             neg_q [9];
  logic             sing_q;
  logic [LaneLat-1:0] sing_dl_q;
  logic             sing_d;

  assign det_neg = det[DetW-1];
  assign adet    = det_neg ? (DetW-1)'(-det) : det[DetW-2:0];
  assign sing_d  = (det == '0) ||
                   (adet < ((DetW-1)'(thr_q) << (2 * FracB)));

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        num_q[k] <= (NumW'(adj[k][AdjW-1] ? AdjW'(-adj[k]) : adj[k])
                     << (2 * FracB + 1)) + NumW'(adet);
        neg_q[k] <= adj[k][AdjW-1] != det_neg;
      end
      den_q  <= {adet, 1'b0};
      sing_q <= sing_d;
      sing_dl_q <= {sing_dl_q[LaneLat-2:0], sing_q};
    end
  end

  elem_t res [9];
  logic  sat [9];

  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[k]),
      .den_i (den_q),
      .neg_i (neg_q[k]),
      .res_o (res[k]),
      .sat_o (sat[k])
    );
  end

  // merge: identity if singular, else results and OR of saturation flags
  localparam logic [ElemW:0] OneRaw = (ElemW+1)'(1) << FracB;
  localparam logic [ElemW:0] MaxRaw = ((ElemW+1)'(1) << (ElemW - 1)) - (ElemW+1)'(1);
  localparam elem_t One = (OneRaw > MaxRaw) ? elem_t'(MaxRaw) : elem_t'(OneRaw);

  elem_t outv_q [9];
  logic  sing_o_q;
  logic  sat_o_q;
  logic  sat_any;

  always_comb begin
    sat_any = 1'b0;
    for (int k = 0; k < 9; k++) begin
      sat_any = sat_any | sat[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        if (sing_dl_q[LaneLat-1]) begin
          outv_q[k] <= (k % 4 == 0) ? One : '0;
        end else begin
          outv_q[k] <= res[k];
        end
      end
      sing_o_q <= sing_dl_q[LaneLat-1];
      sat_o_q  <= !sing_dl_q[LaneLat-1] && sat_any;
    end
  end

  assign out_o.valid     = vld_q[PipeLat-1];
  assign out_o.out_r0c0  = outv_q[0];
  assign out_o.out_r0c1  = outv_q[1];
  assign out_o.out_r0c2  = outv_q[2];
  assign out_o.out_r1c0  = outv_q[3];
  assign out_o.out_r1c1  = outv_q[4];
  assign out_o.out_r1c2  = outv_q[5];
  assign out_o.out_r2c0  = outv_q[6];
  assign out_o.out_r2c1  = outv_q[7];
  assign out_o.out_r2c2  = outv_q[8];
  assign out_o.singular  = sing_o_q;
  assign out_o.saturated = sat_o_q;
endmodule

[dv/matrix_inverse_3x3_core_tb.sv]
// Self-checking testbench for the 3x3 matrix inverse core: queued stimulus, inverse predictor.
`timescale 1ns / 1ps
module matrix_inverse_3x3_core_tb;
  import mi3_pkg::*;

  typedef logic [8:0][ElemW-1:0] mat9_t;
  typedef enum logic [1:0] {ACT_MATRIX, ACT_THRESH, ACT_DRAIN} act_e;
  typedef struct {
    act_e             act;
    mat9_t            mat;
    logic [ThrW-1:0]  thr;
  } action_t;
  typedef struct packed {
    mat9_t inv;
    logic  singular;
    logic  saturated;
  } inverse_t;

  localparam int IdlePct = 11;
  localparam int CalmLo  = 1500;
  localparam int CalmHi  = 2300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [ThrW-1:0] cfg_wdata = '0;

  mi3_in_if  in_if ();
  mi3_out_if out_if ();

  matrix_inverse_3x3_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  action_t         pending[$];
  inverse_t        inverse_q[$];
  logic [ThrW-1:0] thr_model = 31'd1;
  logic            in_fire = 1'b0;
  int              errors = 0;
  int              cyc = 0;
  int              results_seen = 0;
  int              settle = 0;
  int              hold_left = 0;
  bit              held = 1'b0;

  function automatic inverse_t invert(mat9_t a, logic [ThrW-1:0] thr);
    logic signed [127:0] e[9];
    logic signed [127:0] adj[9];
    logic signed [127:0] det;
    logic [159:0] adet, lim, num, den, q;
    inverse_t r;
    for (int k = 0; k < 9; k++) e[k] = $signed(a[k]);
    adj[0] = e[4] * e[8] - e[5] * e[7];
    adj[1] = e[2] * e[7] - e[1] * e[8];
    adj[2] = e[1] * e[5] - e[2] * e[4];
    adj[3] = e[5] * e[6] - e[3] * e[8];
    adj[4] = e[0] * e[8] - e[2] * e[6];
    adj[5] = e[2] * e[3] - e[0] * e[5];
    adj[6] = e[3] * e[7] - e[4] * e[6];
    adj[7] = e[1] * e[6] - e[0] * e[7];
    adj[8] = e[0] * e[4] - e[1] * e[3];
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    adet = {32'b0, (det[127] ? -det : det)};
    lim = {129'b0, thr} << (2 * FracB);
    r = '0;
    if (det == 0 || adet < lim) begin
      for (int k = 0; k < 9; k += 4) r.inv[k] = ElemW'(1) << FracB;
      r.singular = 1'b1;
      return r;
    end
    den = adet << 1;
    for (int k = 0; k < 9; k++) begin
      num = ({32'b0, (adj[k][127] ? -adj[k] : adj[k])} << (2 * FracB + 1)) + adet;
      q = num / den;
      if (adj[k][127] != det[127]) begin
        if (q > 160'h8000_0000) begin
          q = 160'h8000_0000;
          r.saturated = 1'b1;
        end
        r.inv[k] = -q[ElemW-1:0];
      end else begin
        if (q > 160'h7FFF_FFFF) begin
          q = 160'h7FFF_FFFF;
          r.saturated = 1'b1;
        end
        r.inv[k] = q[ElemW-1:0];
      end
    end
    return r;
  endfunction

  // accepted matrices feed the predictor; results are checked against the oldest one
  always @(posedge clk_i) begin
    inverse_t got, want;
    cyc <= cyc + 1;
    in_fire <= in_if.valid && in_if.ready;
    if (in_if.valid && in_if.ready)
      inverse_q.push_back(invert({in_if.in_r2c2, in_if.in_r2c1, in_if.in_r2c0,
                                  in_if.in_r1c2, in_if.in_r1c1, in_if.in_r1c0,
                                  in_if.in_r0c2, in_if.in_r0c1, in_if.in_r0c0},
                                 thr_model));
    if (cfg_we) thr_model <= cfg_wdata;
    if (out_if.valid && out_if.ready) begin
      got = {{out_if.out_r2c2, out_if.out_r2c1, out_if.out_r2c0,
              out_if.out_r1c2, out_if.out_r1c1, out_if.out_r1c0,
              out_if.out_r0c2, out_if.out_r0c1, out_if.out_r0c0},
             out_if.singular, out_if.saturated};
      results_seen <= results_seen + 1;
      if (inverse_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = inverse_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: inverse mismatch, expected %h, actual %h", $time, want, got);
        end
      end
    end
  end

  // matrix sender; threshold writes and drains wait for an empty pipeline
  always @(negedge clk_i) begin
    logic  nv, nwe;
    action_t a;
    nv = in_if.valid && !in_fire;
    nwe = 1'b0;
    if (rst_ni && !nv && pending.size() != 0) begin
      a = pending[0];
      if (a.act == ACT_MATRIX) begin
        settle = 0;
        if ((cyc >= CalmLo && cyc < CalmHi) || $urandom_range(99) >= IdlePct) begin
          void'(pending.pop_front());
          {in_if.in_r2c2, in_if.in_r2c1, in_if.in_r2c0,
           in_if.in_r1c2, in_if.in_r1c1, in_if.in_r1c0,
           in_if.in_r0c2, in_if.in_r0c1, in_if.in_r0c0} <= a.mat;
          nv = 1'b1;
        end
      end else if (inverse_q.size() == 0 && !in_fire) begin
        settle++;
        if (settle > 50) begin
          settle = 0;
          void'(pending.pop_front());
          if (a.act == ACT_THRESH) begin
            nwe = 1'b1;
            cfg_wdata <= a.thr;
          end
        end
      end
    end
    in_if.valid <= nv;
    cfg_we <= nwe;
  end

  // result receiver, with one long hold-off to back the pipeline up
  always @(negedge clk_i) begin
    logic r;
    if (hold_left > 0) begin
      hold_left--;
      r = 1'b0;
    end else if (!held && results_seen >= 150) begin
      held = 1'b1;
      hold_left = 300;
      r = 1'b0;
    end else begin
      r = (cyc >= CalmLo && cyc < CalmHi) || $urandom_range(99) >= IdlePct;
    end
    out_if.ready <= rst_ni && r;
  end

  function automatic logic [ElemW-1:0] modest();
    return ElemW'(int'($urandom_range(0, 2 ** 19)) - 2 ** 18);
  endfunction

  function automatic mat9_t random_matrix();
    mat9_t m;
    int pick;
    pick = $urandom_range(99);
    for (int k = 0; k < 9; k++) m[k] = (pick < 70) ? modest() : $urandom;
    if (pick >= 90) begin
      // rank-deficient: third row a copy of the first
      m[6] = m[0];
      m[7] = m[1];
      m[8] = m[2];
    end else if (pick >= 85) begin
      for (int k = 0; k < 9; k++) m[k] = ElemW'(int'($urandom_range(0, 8)) - 4);
    end
    return m;
  endfunction

  task automatic add_matrix(mat9_t m);
    action_t a;
    a.act = ACT_MATRIX;
    a.mat = m;
    a.thr = '0;
    pending.push_back(a);
  endtask

  task automatic add_ctrl(act_e act, logic [ThrW-1:0] thr);
    action_t a;
    a.act = act;
    a.mat = '0;
    a.thr = thr;
    pending.push_back(a);
  endtask

  function automatic mat9_t diag(logic [ElemW-1:0] d0, logic [ElemW-1:0] d1,
                                 logic [ElemW-1:0] d2);
    mat9_t m;
    m = '0;
    m[0] = d0;
    m[4] = d1;
    m[8] = d2;
    return m;
  endfunction

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) add_matrix(random_matrix());
  endtask

  initial begin
    in_if.valid = 1'b0;
    {in_if.in_r2c2, in_if.in_r2c1, in_if.in_r2c0,
     in_if.in_r1c2, in_if.in_r1c1, in_if.in_r1c0,
     in_if.in_r0c2, in_if.in_r0c1, in_if.in_r0c0} = '0;
    out_if.ready = 1'b0;

    // directed: identity, zero, extremes, negative determinant, singular copies
    add_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    add_matrix('0);
    add_matrix({9{32'h7FFF_FFFF}});
    add_matrix({9{32'h8000_0000}});
    add_matrix(diag(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    add_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    add_matrix(diag(32'h0002_0000, 32'hFFFE_0000, 32'h0003_0000));
    add_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    add_matrix(diag(32'h0000_0100, 32'h0001_0000, 32'h0001_0000));
    add_matrix({32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7, 32'h8, 32'hA} << 16);
    add_matrix({32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                32'hFFFF_0000, 32'h0001_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0});
    add_ctrl(ACT_THRESH, 31'd0);
    add_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    add_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
    add_matrix(diag(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
    add_matrix('0);
    add_random(200);
    add_ctrl(ACT_DRAIN, '0);
    add_random(200);
    add_ctrl(ACT_THRESH, 31'h7FFF_FFFF);
    add_matrix({9{32'h8000_0000}});
    add_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_random(40);
    add_ctrl(ACT_THRESH, 31'h0001_0000);
    add_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    add_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0000_FFFF));
    add_random(150);
    add_ctrl(ACT_THRESH, 31'($urandom_range(0, 32'h0010_0000)));
    add_random(150);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending.size() == 0 && !in_if.valid && inverse_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && inverse_q.size() == 0)
      $display("matrix_inverse_3x3_core_tb: done, clean");
    else
      $display("matrix_inverse_3x3_core_tb: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("matrix_inverse_3x3_core_tb: done, errors");
    $finish;
  end
endmodule
